/* rtl/dtk_pkg.sv */
// Package with the shared types, constants and ranking function of the top-K tracker.
package dtk_pkg;

    localparam int KEY_BITS       = 10;
    localparam int COUNT_BITS     = 32;
    localparam int CFG_BITS       = 5;
    localparam logic [CFG_BITS-1:0] TOP_SIZE_RESET = 5'd16;

    typedef struct packed {
        logic                mode;
        logic [KEY_BITS-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   entry_key;
        logic [COUNT_BITS-1:0] entry_count;
        logic                  in_top;
        logic                  valid_res;
        logic                  last;
    } out_item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
    } heap_ent_t;

    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_UP,
        ST_PLACE,
        ST_EV0,
        ST_EV1,
        ST_SDL,
        ST_SDR,
        ST_OUT,
        ST_EMPTY,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // True when entry a ranks above entry b: higher count, or smaller key on equal counts.
    function automatic logic ranks_above(heap_ent_t a, heap_ent_t b);
        logic r;
        if (a.count != b.count) begin
            r = a.count > b.count;
        end else begin
            r = a.key < b.key;
        end
        return r;
    endfunction

endpackage

/* rtl/dtk_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module dtk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/dtk_heap.sv */
// Heap slot register file with one write port and one read port.
module dtk_heap
    import dtk_pkg::*;
#(
    parameter int DEPTH = 17
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  heap_ent_t                wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output heap_ent_t                rdata
);

    heap_ent_t slot_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            slot_reg[waddr] <= wdata;
        end
    end

    assign rdata = slot_reg[raddr];

endmodule

/* rtl/dynamic_top_k_frequency_tracker.sv */
// Top level of the top-K frequency tracker: control sequencer, key tables and heap.
//
// Input channel s_valid/s_ready/s_data carries one transaction per command: mode 0 counts
// one occurrence of s_data.key, mode 1 reports the held entries. Results leave on
// m_valid/m_ready/m_data through an output register. An add gives one result once
// its heap walk is done: a rising entry climbs one level per ST_UP step, a sinking
// entry passes ST_SDL and ST_SDR for each level, and an eviction walk follows when the
// heap overflows. A report of n entries scans the heap slot file once per emitted
// entry. cfg_valid/cfg_ready/cfg_data writes top_size and is always ready.
// After reset the block runs a clearing pass over all 2**KEY_BITS (1024) addresses of
// the count and position memories; s_ready stays low until it ends. A stalled receiver
// holds the output register; the sequencer waits for it before loading the next result,
// and a new command is taken once the previous result is in the output register.
module dynamic_top_k_frequency_tracker
    import dtk_pkg::*;
#(
    parameter int TOPK_MAX = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_data
);

    localparam int SLOTS    = TOPK_MAX + 1;
    localparam int IDX_BITS = $clog2(SLOTS);
    localparam int POS_BITS = $clog2(TOPK_MAX + 2);
    localparam int CH_BITS  = IDX_BITS + 2;
    localparam int KEYS     = 1 << KEY_BITS;
    localparam logic [POS_BITS-1:0] POS_ABSENT = '1;

    state_t                state_reg, state_next;
    logic [KEY_BITS-1:0]   clr_reg, clr_next;
    logic [CFG_BITS-1:0]   top_size_reg;
    logic [POS_BITS-1:0]   fill_reg, fill_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  in_top_reg, in_top_next;
    logic                  up_reg, up_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    heap_ent_t             cur_reg, cur_next;
    heap_ent_t             best_reg, best_next;
    logic [IDX_BITS-1:0]   best_idx_reg, best_idx_next;
    logic                  have_reg, have_next;
    logic [IDX_BITS-1:0]   scan_reg, scan_next;
    logic [POS_BITS-1:0]   rank_reg, rank_next;
    logic [SLOTS-1:0]      emitted_reg, emitted_next;
    logic                  m_valid_reg;
    out_item_t             m_data_reg;

    logic                  cnt_we, pos_we, heap_we;
    logic [KEY_BITS-1:0]   cnt_waddr, pos_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
    logic [POS_BITS-1:0]   pos_wdata, pos_rdata;
    logic [IDX_BITS-1:0]   heap_waddr, heap_raddr;
    heap_ent_t             heap_wdata, heap_rd;
    logic                  out_free, out_load;
    out_item_t             out_item;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [IDX_BITS-1:0]   parent;
    logic [CH_BITS-1:0]    left, right;
    logic                  overflow;

    dtk_ram #(.WIDTH(COUNT_BITS), .DEPTH(KEYS)) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (s_data.key),
        .rdata (cnt_rdata)
    );

    dtk_ram #(.WIDTH(POS_BITS), .DEPTH(KEYS)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (s_data.key),
        .rdata (pos_rdata)
    );

    dtk_heap #(.DEPTH(SLOTS)) u_heap (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rd)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign cnt_inc   = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
    assign parent    = IDX_BITS'((idx_reg - 1'b1) >> 1);
    assign left      = {1'b0, idx_reg, 1'b1};
    assign right     = left + 1'b1;
    assign overflow  = (fill_reg > top_size_reg) || (fill_reg > POS_BITS'(TOPK_MAX));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            top_size_reg <= TOP_SIZE_RESET;
            fill_reg     <= '0;
            up_reg       <= 1'b0;
            have_reg     <= 1'b0;
            emitted_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            fill_reg    <= fill_next;
            up_reg      <= up_next;
            have_reg    <= have_next;
            emitted_reg <= emitted_next;
            if (cfg_valid && cfg_ready) begin
                top_size_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        cnt_reg      <= cnt_next;
        in_top_reg   <= in_top_next;
        idx_reg      <= idx_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        scan_reg     <= scan_next;
        rank_reg     <= rank_next;
        if (out_load) begin
            m_data_reg <= out_item;
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        fill_next     = fill_reg;
        key_next      = key_reg;
        cnt_next      = cnt_reg;
        in_top_next   = in_top_reg;
        up_next       = up_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        have_next     = have_reg;
        scan_next     = scan_reg;
        rank_next     = rank_reg;
        emitted_next  = emitted_reg;
        cnt_we        = 1'b0;
        cnt_waddr     = key_reg;
        cnt_wdata     = cnt_inc;
        pos_we        = 1'b0;
        pos_waddr     = cur_reg.key;
        pos_wdata     = POS_BITS'(idx_reg);
        heap_we       = 1'b0;
        heap_waddr    = idx_reg;
        heap_wdata    = heap_rd;
        heap_raddr    = idx_reg;
        out_load      = 1'b0;
        out_item      = '{entry_key: key_reg, entry_count: cnt_reg, in_top: in_top_reg,
                          valid_res: 1'b1, last: 1'b1};
        case (state_reg)
            ST_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = POS_ABSENT;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    key_next = s_data.key;
                    if (s_data.mode == MODE_ADD) begin
                        state_next = ST_LOOK;
                    end else if (fill_reg == '0) begin
                        state_next = ST_EMPTY;
                    end else begin
                        scan_next    = '0;
                        have_next    = 1'b0;
                        rank_next    = '0;
                        emitted_next = '0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_LOOK: begin
                cnt_we       = 1'b1;
                cnt_next     = cnt_inc;
                cur_next.key = key_reg;
                cur_next.count = cnt_inc;
                in_top_next  = 1'b1;
                up_next      = 1'b0;
                if (pos_rdata != POS_ABSENT && pos_rdata < fill_reg) begin
                    idx_next   = pos_rdata[IDX_BITS-1:0];
                    state_next = ST_SDL;
                end else if (fill_reg <= POS_BITS'(TOPK_MAX)) begin
                    idx_next   = fill_reg[IDX_BITS-1:0];
                    fill_next  = fill_reg + 1'b1;
                    up_next    = 1'b1;
                    state_next = ST_UP;
                end else begin
                    in_top_next = (pos_rdata != POS_ABSENT);
                    state_next  = ST_OUT;
                end
            end
            ST_UP: begin
                heap_raddr = parent;
                if (idx_reg == '0 || !ranks_above(heap_rd, cur_reg)) begin
                    state_next = ST_PLACE;
                end else begin
                    heap_we   = 1'b1;
                    pos_we    = 1'b1;
                    pos_waddr = heap_rd.key;
                    idx_next  = parent;
                end
            end
            ST_PLACE: begin
                heap_we    = 1'b1;
                heap_wdata = cur_reg;
                pos_we     = 1'b1;
                if (up_reg && overflow) begin
                    state_next = ST_EV0;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_EV0: begin
                heap_raddr = '0;
                pos_we     = 1'b1;
                pos_waddr  = heap_rd.key;
                pos_wdata  = POS_ABSENT;
                up_next    = 1'b0;
                fill_next  = fill_reg - 1'b1;
                if (heap_rd.key == key_reg) begin
                    in_top_next = 1'b0;
                end
                if (fill_reg == POS_BITS'(1)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_EV1;
                end
            end
            ST_EV1: begin
                heap_raddr = fill_reg[IDX_BITS-1:0];
                cur_next   = heap_rd;
                idx_next   = '0;
                state_next = ST_SDL;
            end
            ST_SDL: begin
                heap_raddr = left[IDX_BITS-1:0];
                best_next  = cur_reg;
                have_next  = 1'b0;
                if (left < CH_BITS'(fill_reg)) begin
                    if (ranks_above(cur_reg, heap_rd)) begin
                        best_next     = heap_rd;
                        best_idx_next = left[IDX_BITS-1:0];
                        have_next     = 1'b1;
                    end
                    state_next = ST_SDR;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_SDR: begin
                heap_raddr = right[IDX_BITS-1:0];
                if (right < CH_BITS'(fill_reg) && ranks_above(best_reg, heap_rd)) begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    pos_waddr  = heap_rd.key;
                    idx_next   = right[IDX_BITS-1:0];
                    state_next = ST_SDL;
                end else if (have_reg) begin
                    heap_we    = 1'b1;
                    heap_wdata = best_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = best_reg.key;
                    idx_next   = best_idx_reg;
                    state_next = ST_SDL;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                out_item = '{entry_key: '0, entry_count: '0, in_top: 1'b0,
                             valid_res: 1'b0, last: 1'b1};
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                heap_raddr = scan_reg;
                if (!emitted_reg[scan_reg] && (!have_reg || ranks_above(heap_rd, best_reg)))
                begin
                    best_next     = heap_rd;
                    best_idx_next = scan_reg;
                    have_next     = 1'b1;
                end
                scan_next = scan_reg + 1'b1;
                if (POS_BITS'(scan_reg) + 1'b1 == fill_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                out_item = '{entry_key: best_reg.key, entry_count: best_reg.count,
                             in_top: 1'b1, valid_res: 1'b1,
                             last: (rank_reg + 1'b1 == fill_reg)};
                if (out_free) begin
                    out_load                   = 1'b1;
                    emitted_next[best_idx_reg] = 1'b1;
                    rank_next                  = rank_reg + 1'b1;
                    scan_next                  = '0;
                    have_next                  = 1'b0;
                    if (rank_reg + 1'b1 == fill_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= POS_BITS'(TOPK_MAX + 1))
        else $error("Heap fill exceeds the slot count.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("A second transaction was taken while one was in work.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.valid_res) |-> (m_data.last && !m_data.in_top))
        else $error("An empty report result is not a lone final result.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EV0) |-> (fill_reg != '0))
        else $error("Eviction started on an empty heap.");
`endif

endmodule
